// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3d;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_CHAR     = 3'd1,
        ST_AFTER_PAD    = 3'd2,
        ST_SHORT        = 3'd3,
        ST_PAD_EARLY    = 3'd4,
        ST_TOO_MUCH_PAD = 3'd5
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // One queued group: up to three bytes, most significant first.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  cnt;
        t_status     status;
        logic        eos;
    } t_grp;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = 6'd0;
        case (c) inside
            [8'h41:8'h5a]: s.val = 6'(c - 8'h41);
            [8'h61:8'h7a]: s.val = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: s.val = 6'(c - 8'h30 + 8'd52);
            8'h2b:         s.val = 6'd62;
            8'h2f:         s.val = 6'd63;
            default:       s.ok  = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output b64d_pkg::t_grp o_grp
);
    import b64d_pkg::*;

    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic [2:0]  r_pad, n_pad;
    t_status     r_err, n_err;
    logic        w_done;
    logic        w_emit;
    logic        w_accept;
    t_sextet     w_sx;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_sx     = sextet_of(i_char);
    assign o_push   = w_accept && w_emit;

    always_comb begin
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_pad        = r_pad;
        n_err        = r_err;
        w_done       = 1'b0;
        w_emit       = 1'b0;
        o_grp.bytes  = n_acc;
        o_grp.cnt    = 2'd3;
        o_grp.status = ST_OK;
        o_grp.eos    = i_last;
        if (r_err == ST_OK) begin
            if (i_char == CHAR_PAD) begin
                if (r_pad != 3'd7) begin
                    n_pad = r_pad + 3'd1;
                end
                n_acc = {r_acc[17:0], 6'd0};
            end else if (r_pad != 3'd0) begin
                n_err = ST_AFTER_PAD;
            end else if (!w_sx.ok) begin
                n_err = ST_BAD_CHAR;
            end else begin
                n_acc = {r_acc[17:0], w_sx.val};
            end
            if (n_err == ST_OK) begin
                w_done = (r_pos == 2'd3);
                n_pos  = r_pos + 2'd1;
            end
            if (w_done) begin
                if (n_pad != 3'd0 && !i_last) begin
                    n_err = ST_PAD_EARLY;
                end else if (n_pad > 3'd2) begin
                    n_err = ST_TOO_MUCH_PAD;
                end else begin
                    w_emit      = 1'b1;
                    o_grp.bytes = n_acc;
                    o_grp.cnt   = 2'd3 - n_pad[1:0];
                end
                n_acc = 24'd0;
                n_pad = 3'd0;
            end else if (n_err == ST_OK && i_last) begin
                n_err = ST_SHORT;
            end
        end
        if (i_last) begin
            if (n_err != ST_OK) begin
                w_emit       = 1'b1;
                o_grp.bytes  = 24'd0;
                o_grp.cnt    = 2'd1;
                o_grp.status = n_err;
            end
            n_acc = 24'd0;
            n_pos = 2'd0;
            n_pad = 3'd0;
            n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 24'd0;
            r_pos <= 2'd0;
            r_pad <= 3'd0;
            r_err <= ST_OK;
        end else if (w_accept) begin
            r_acc <= n_acc;
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_grp i_grp,
    input  logic           i_pop,
    output b64d_pkg::t_grp o_grp,
    output logic           o_full,
    output logic           o_empty
);
    import b64d_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_grp          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_grp   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64d_back.sv =====
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64d_pkg::t_grp    i_grp,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    output logic [7:0]        o_byte,
    output b64d_pkg::t_status o_status,
    output logic              o_last,
    input  logic              i_ready
);
    import b64d_pkg::*;

    logic [23:0] r_bytes;
    logic [1:0]  r_cnt;
    t_status     r_st;
    logic        r_eos;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    t_status     r_ost;
    logic        r_olast;
    logic        w_free;
    logic        w_adv;

    assign w_free   = !r_ovalid || i_ready;
    assign w_adv    = w_free && (r_cnt != 2'd0);
    assign o_pop    = !i_empty && ((r_cnt == 2'd0) || (w_adv && r_cnt == 2'd1));
    assign o_valid  = r_ovalid;
    assign o_byte   = r_obyte;
    assign o_status = r_ost;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_obyte <= r_bytes[23:16];
            r_ost   <= r_st;
            r_olast <= r_eos && (r_cnt == 2'd1);
        end
        if (o_pop) begin
            r_bytes <= i_grp.bytes;
            r_st    <= i_grp.status;
            r_eos   <= i_grp.eos;
        end else if (w_adv) begin
            r_bytes <= {r_bytes[15:0], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_free) begin
                r_ovalid <= (r_cnt != 2'd0);
            end
            if (o_pop) begin
                r_cnt <= i_grp.cnt;
            end else if (w_adv) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Channel   Direction  tdata (low bit up)                       tuser  tlast
// s_axis    in         char_in[7:0]                             -      last_char
// m_axis    out        data_byte[7:0], status[10:8], 0[15:11]   -      end_of_string
//
// One character is taken every cycle while the group queue has room.
// A completed group leaves the back end at one byte per cycle while m_axis is ready,
// so four characters (three bytes) never fall behind.
// Reset is synchronous and clears decoder state, queue pointers and output valid.
// A stalled m_axis holds its transaction; the queue absorbs FIFO_DEPTH groups.
module base64_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_byte, status, zero fill
    output logic        m_axis_tlast
);
    import b64d_pkg::*;

    t_grp       w_push_grp;
    t_grp       w_pop_grp;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    logic [7:0] w_byte;
    t_status    w_status;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_grp   (w_push_grp)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_push_grp),
        .i_pop   (w_pop),
        .o_grp   (w_pop_grp),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grp    (w_pop_grp),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .o_byte   (w_byte),
        .o_status (w_status),
        .o_last   (m_axis_tlast),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, w_status, w_byte};

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("group pushed into a full queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_push_grp.cnt != 2'd0)
        else $error("empty group pushed");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status != ST_OK |-> w_byte == 8'd0 && m_axis_tlast)
        else $error("error result without zero byte or end mark");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import b64d_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int CHAR_TARGET    = 430;

    typedef struct {
        logic [7:0] data;
        t_status    status;
        logic       eos;
    } exp_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // char_in[7:0]
    logic        s_axis_tlast = 1'b0;    // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;           // data_byte[7:0], status[10:8], zero fill[15:11]
    logic        m_axis_tlast;           // end_of_string

    exp_beat_t   exp_q[$];
    logic [7:0]  line_q[$];

    logic [23:0] dec_acc;
    logic [1:0]  dec_pos;
    logic [2:0]  dec_pads;
    t_status     dec_err;

    int mismatches = 0;
    int sent_chars = 0;
    int idle_cycles = 0;
    int rx_hold_len = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;

    base64_stream_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sym_value(logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'("A");
        if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    function automatic logic [7:0] sym_char(logic [5:0] v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_expect(logic [7:0] data, t_status st, logic eos);
        exp_beat_t b;
        b.data   = data;
        b.status = st;
        b.eos    = eos;
        exp_q.insert(exp_q.size(), b);
    endtask

    task automatic clear_decoder();
        dec_acc  = '0;
        dec_pos  = '0;
        dec_pads = '0;
        dec_err  = ST_OK;
    endtask

    task automatic predict_char(logic [7:0] c, logic last);
        int  v;
        int  nb;
        logic done;
        done = 1'b0;
        if (dec_err == ST_OK) begin
            if (c == CHAR_PAD) begin
                if (dec_pads < 7) dec_pads++;
                dec_acc = {dec_acc[17:0], 6'd0};
            end else if (dec_pads != 0) begin
                dec_err = ST_AFTER_PAD;
            end else begin
                v = sym_value(c);
                if (v < 0) dec_err = ST_BAD_CHAR;
                else dec_acc = {dec_acc[17:0], 6'(v)};
            end
            if (dec_err == ST_OK) begin
                if (dec_pos == 2'd3) begin
                    done = 1'b1;
                    dec_pos = '0;
                end else begin
                    dec_pos++;
                end
            end
            if (done) begin
                if (dec_pads != 0 && !last) begin
                    dec_err = ST_PAD_EARLY;
                end else if (dec_pads > 2) begin
                    dec_err = ST_TOO_MUCH_PAD;
                end else begin
                    nb = 3 - int'(dec_pads);
                    for (int k = 0; k < nb; k++)
                        push_expect(dec_acc[23 - 8 * k -: 8], ST_OK, last && (k == nb - 1));
                end
                dec_acc  = '0;
                dec_pads = '0;
            end else if (dec_err == ST_OK && last) begin
                dec_err = ST_SHORT;
            end
        end
        if (last) begin
            if (dec_err != ST_OK) push_expect(8'h00, dec_err, 1'b1);
            clear_decoder();
        end
    endtask

    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch %s: expected %0h got %0h at %0t", what, exp_val, got_val, $time);
        mismatches++;
    endtask

    // Called at a rising edge; returns at the edge of acceptance.
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_char(c, last);
        sent_chars++;
    endtask

    task automatic send_text(string s, bit term);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], term && (i == s.len() - 1));
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_char(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic load_encoded(int nbytes);
        logic [23:0] grp;
        int take;
        line_q.delete();
        for (int i = 0; i < nbytes; i += 3) begin
            take = (nbytes - i > 3) ? 3 : nbytes - i;
            grp = '0;
            for (int k = 0; k < take; k++) grp[23 - 8 * k -: 8] = 8'($urandom);
            for (int k = 0; k < 4; k++) begin
                if (k <= take) line_q.insert(line_q.size(), sym_char(grp[23 - 6 * k -: 6]));
                else line_q.insert(line_q.size(), CHAR_PAD);
            end
        end
    endtask

    task automatic test_alphabet();
        send_text("AZaz09+/", 1'b1);
    endtask

    task automatic test_padding();
        send_text("TWE=", 1'b1);
        send_text("TQ==", 1'b1);
    endtask

    task automatic test_errors();
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        send_char("T", 1'b0);
        send_char(8'hff, 1'b1);
        send_text("TW", 1'b1);
        send_text("T=A", 1'b1);
        send_text("AA==", 1'b0);
        send_text("A", 1'b1);
        send_text("A===", 1'b1);
    endtask

    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_gaps_on  = 1'b0;
        rx_hold_len = 200;
        repeat (12) begin
            load_encoded($urandom_range(3, 6));
            send_line();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int r;
        int pos;
        while (sent_chars < CHAR_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 84) load_encoded($urandom_range(1, 6));
            if (r >= 80 && r < 84) begin
                line_q.delete();
                repeat ($urandom_range(1, 6))
                    line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
            end else if (r >= 84 && r < 88) begin
                pos = $urandom_range(0, line_q.size() - 1);
                line_q[pos] = 8'($urandom_range(0, 255));
            end else if (r >= 88 && r < 92) begin
                repeat ($urandom_range(1, 3))
                    if (line_q.size() > 1) void'(line_q.pop_back());
            end else if (r >= 92 && r < 96) begin
                line_q.insert($urandom_range(0, line_q.size() - 1), CHAR_PAD);
            end else if (r >= 96) begin
                load_encoded($urandom_range(1, 6));
                repeat (4) line_q.insert(line_q.size(), sym_char(6'($urandom)));
            end
            send_line();
        end
    endtask

    initial begin : rx_proc
        int gap;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_gaps_on && $urandom_range(0, 99) < 25) begin
                gap = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        exp_beat_t b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, int'(m_axis_tdata));
            end else begin
                b = exp_q.pop_front();
                if (m_axis_tdata[7:0] != b.data)
                    report_mismatch("data_byte", int'(b.data), int'(m_axis_tdata[7:0]));
                if (m_axis_tdata[10:8] != b.status)
                    report_mismatch("status", int'(b.status), int'(m_axis_tdata[10:8]));
                if (m_axis_tdata[15:11] != 5'd0)
                    report_mismatch("fill", 0, int'(m_axis_tdata[15:11]));
                if (m_axis_tlast != b.eos)
                    report_mismatch("end_of_string", int'(b.eos), int'(m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alphabet();
        test_padding();
        test_errors();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && exp_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== base64_stream_decoder.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
bench/tb_top.sv
